[design/cdq_pkg.sv]
// Shared types and constants of the circular deque unit.
`default_nettype none

package cdq_pkg;

    localparam int DEPTH  = 8;
    localparam int NCELL  = DEPTH - 1;
    localparam int REQ_W  = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
    localparam logic [REQ_W-1:0] REQ_PEEK_REAR  = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STAT_W-1:0]        status;
        logic                     now_empty;
        logic                     now_full;
    } t_rsp;

    typedef struct packed {
        logic shift_r;
        logic shift_l;
        logic push_rear;
        logic pop_rear;
    } t_cell_ctrl;

endpackage

`default_nettype wire

[design/cdq_req_if.sv]
// Request channel interface of the circular deque unit.
`default_nettype none

interface cdq_req_if;
    logic          valid;
    logic          ready;
    cdq_pkg::t_req payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/cdq_rsp_if.sv]
// Response channel interface of the circular deque unit.
`default_nettype none

interface cdq_rsp_if;
    logic          valid;
    logic          ready;
    cdq_pkg::t_rsp payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/cdq_cell.sv]
// One storage cell of the deque chain, holding one element and its valid flag.
`default_nettype none

module cdq_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire cdq_pkg::t_cell_ctrl             i_ctrl,
    input  wire logic signed [cdq_pkg::DATA_W-1:0] i_push_data,
    input  wire logic signed [cdq_pkg::DATA_W-1:0] i_left_data,
    input  wire logic                            i_left_valid,
    input  wire logic signed [cdq_pkg::DATA_W-1:0] i_right_data,
    input  wire logic                            i_right_valid,
    output logic signed [cdq_pkg::DATA_W-1:0]    o_data,
    output logic                                 o_valid
);

    logic signed [cdq_pkg::DATA_W-1:0] r_data;
    logic signed [cdq_pkg::DATA_W-1:0] n_data;
    logic                              r_valid;
    logic                              n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.shift_r) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_ctrl.shift_l) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_ctrl.push_rear && !r_valid && i_left_valid) begin
            n_data  = i_push_data;
            n_valid = 1'b1;
        end else if (i_ctrl.pop_rear && r_valid && !i_right_valid) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

[design/circular_deque_unit.sv]
// Top level of the circular deque unit: cell chain, request decode and response register.
//
// The deque holds up to DEPTH-1 elements in a chain of cells ordered from front to rear;
// a push at the front or a pop from the front shifts every cell by one place in the same
// cycle, while a rear push fills only the first free cell and a rear pop clears only the
// last occupied cell. Each request yields one response transaction in the cycle after
// it is accepted, and a new request is accepted every cycle as long as the response
// register is empty or being drained, so the sustained rate is one request per cycle.
`default_nettype none

module circular_deque_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cdq_req_if.sink    i_req,
    cdq_rsp_if.source  o_rsp
);

    localparam int NC = cdq_pkg::NCELL;

    logic signed [cdq_pkg::DATA_W-1:0] w_data [NC];
    logic [NC-1:0]                     w_valid;
    logic [NC:0]                       w_vleft;
    logic [NC:0]                       w_vright;
    logic signed [cdq_pkg::DATA_W-1:0] w_rear_data;
    logic                              w_empty;
    logic                              w_full;
    logic                              w_accept;
    cdq_pkg::t_cell_ctrl               w_ctrl;
    cdq_pkg::t_cell_ctrl               w_ctrl_req;
    cdq_pkg::t_rsp                     n_rsp;
    cdq_pkg::t_rsp                     r_rsp;
    logic                              r_out_valid;
    logic                              n_out_valid;

    assign w_vleft  = {w_valid, 1'b1};
    assign w_vright = {1'b0, w_valid};
    assign w_empty  = !w_valid[0];
    assign w_full   = w_valid[NC-1];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_ctrl      = w_accept ? w_ctrl_req : '0;

    genvar g;
    generate
        for (g = 0; g < NC; g++) begin : g_cell
            logic signed [cdq_pkg::DATA_W-1:0] w_ld;
            logic signed [cdq_pkg::DATA_W-1:0] w_rd;
            if (g == 0) begin : g_first
                assign w_ld = i_req.payload.value;
            end else begin : g_mid
                assign w_ld = w_data[g-1];
            end
            if (g == NC - 1) begin : g_last
                assign w_rd = '0;
            end else begin : g_inner
                assign w_rd = w_data[g+1];
            end
            cdq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_push_data  (i_req.payload.value),
                .i_left_data  (w_ld),
                .i_left_valid (w_vleft[g]),
                .i_right_data (w_rd),
                .i_right_valid(w_vright[g+1]),
                .o_data       (w_data[g]),
                .o_valid      (w_valid[g])
            );
        end
    endgenerate

    always_comb begin
        w_rear_data = '0;
        for (int i = 0; i < NC; i++) begin
            if (w_valid[i] && !w_vright[i+1]) begin
                w_rear_data = w_rear_data | w_data[i];
            end
        end
    end

    always_comb begin
        w_ctrl_req         = '0;
        n_rsp.read_value   = '0;
        n_rsp.status       = cdq_pkg::STAT_OK;
        n_rsp.now_empty    = w_empty;
        n_rsp.now_full     = w_full;
        case (i_req.payload.req_type)
            cdq_pkg::REQ_PUSH_REAR, cdq_pkg::REQ_PUSH_FRONT: begin
                if (w_full) begin
                    n_rsp.status = cdq_pkg::STAT_FULL;
                end else begin
                    w_ctrl_req.push_rear = (i_req.payload.req_type == cdq_pkg::REQ_PUSH_REAR);
                    w_ctrl_req.shift_r   = (i_req.payload.req_type == cdq_pkg::REQ_PUSH_FRONT);
                    n_rsp.now_empty      = 1'b0;
                    n_rsp.now_full       = w_vleft[NC-1];
                end
            end
            cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_REAR: begin
                if (w_empty) begin
                    n_rsp.status = cdq_pkg::STAT_EMPTY;
                end else begin
                    w_ctrl_req.shift_l  = (i_req.payload.req_type == cdq_pkg::REQ_POP_FRONT);
                    w_ctrl_req.pop_rear = (i_req.payload.req_type == cdq_pkg::REQ_POP_REAR);
                    n_rsp.read_value    = (i_req.payload.req_type == cdq_pkg::REQ_POP_FRONT)
                                          ? w_data[0] : w_rear_data;
                    n_rsp.now_empty     = !w_vright[1];
                    n_rsp.now_full      = 1'b0;
                end
            end
            cdq_pkg::REQ_PEEK_FRONT: begin
                if (w_empty) begin
                    n_rsp.status = cdq_pkg::STAT_EMPTY;
                end else begin
                    n_rsp.read_value = w_data[0];
                end
            end
            cdq_pkg::REQ_PEEK_REAR: begin
                if (w_empty) begin
                    n_rsp.status = cdq_pkg::STAT_EMPTY;
                end else begin
                    n_rsp.read_value = w_rear_data;
                end
            end
            default: begin
                n_rsp.status = cdq_pkg::STAT_OK;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

endmodule

`default_nettype wire

[design/cdq_checker.sv]
// Port-level checker of the circular deque unit and its bind statement.
`default_nettype none

module cdq_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_req_valid,
    input wire logic          i_req_ready,
    input wire logic          i_rsp_valid,
    input wire logic          i_rsp_ready,
    input wire cdq_pkg::t_rsp i_rsp_payload
);

    a_rsp_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> i_rsp_valid)
        else $error("No response transaction after an accepted request.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_payload.status == cdq_pkg::STAT_OK ||
                         i_rsp_payload.status == cdq_pkg::STAT_FULL ||
                         i_rsp_payload.status == cdq_pkg::STAT_EMPTY))
        else $error("Response carries an undefined status code.");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_payload.status != cdq_pkg::STAT_OK
        |-> i_rsp_payload.read_value == '0)
        else $error("Rejected request returned a non-zero value.");

    a_empty_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_payload.now_empty && i_rsp_payload.now_full))
        else $error("Deque reported as both empty and full.");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_payload))
        else $error("Stalled response transaction changed.");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_payload(o_rsp.payload)
);

`default_nettype wire
